/* design/rbec_pkg.sv */
// Shared types, constants and helpers for the rotating beacon edge capture block.
package rbec_pkg;

	// Table and time geometry
	localparam int BEACON_SLOTS = 8;
	localparam int TIME_BITS    = 32;
	localparam int IDX_W        = (BEACON_SLOTS > 1) ? $clog2(BEACON_SLOTS) : 1;
	localparam int CNT_W        = $clog2(BEACON_SLOTS + 1);
	localparam int STAT_W       = 8;

	// Event kinds carried on the input tuser bit
	localparam logic EVT_TICK  = 1'b0;
	localparam logic EVT_LASER = 1'b1;

	// Acquisition mode
	typedef enum logic [1:0] {
		ACQ_DISABLED = 2'd0,
		ACQ_IGNORE   = 2'd1,
		ACQ_STD      = 2'd2,
		ACQ_LAST     = 2'd3
	} acq_mode_t;

	// Controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SEND = 1'b1
	} ctl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take;    // input beat accepted this cycle
		logic start;   // accepted tick commits: load first result beat
		logic next;    // result beat taken, more follow: load next slot
		logic finish;  // final result beat taken: clear the record
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic commit;  // the offered input beat would commit a record
		logic last;    // the held result beat is the final one
	} dp_stat_t;

	// Saturating increment of an 8-bit statistic
	function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
		return (v == {STAT_W{1'b1}}) ? v : v + STAT_W'(1);
	endfunction

endpackage

/* design/rotating_beacon_edge_capture.sv */
// Top level of the rotating beacon edge capture block: stream ports and packing.
//
//  channel | dir | tdata                       | tuser        | tlast
//  s_*     | in  | laser_level, timestamp      | event_kind   | -
//  m_*     | out | rotation record slot fields | slot_valid   | last
//
// A laser event or an extending tick is accepted whenever the controller is idle.
// A committing tick is accepted and then followed by max(1, beacons) result beats, each
// sent while m_tready is high; the result register sends one slot a beat.
// s_tready is low while a record is being sent; m_tready low holds the beat.
// arst_n clears mode, counts, statistics and the controller; the first tick
// after reset emits an all-zero record.
module rotating_beacon_edge_capture
	import rbec_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // laser_level[0], timestamp[32:1], zero pad[39:33]
	input  logic         s_tuser,   // event_kind[0]
	output logic         m_tvalid,
	input  logic         m_tready,
	// rotation_start[31:0], rotation_end[63:32], beacon_total[67:64],
	// beacon_index[70:68], fall_time[102:71], rise_time[134:103],
	// overflow_count[142:135], overlap_count[150:143],
	// unexpected_count[158:151], zero pad[159]
	output logic [159:0] m_tdata,
	output logic         m_tuser,   // slot_valid[0]
	output logic         m_tlast
);

	dp_cmd_t              cmd;
	dp_stat_t             stat;
	logic [TIME_BITS-1:0] rotation_start;
	logic [TIME_BITS-1:0] rotation_end;
	logic [CNT_W-1:0]     beacon_total;
	logic [IDX_W-1:0]     beacon_index;
	logic [TIME_BITS-1:0] fall_time;
	logic [TIME_BITS-1:0] rise_time;
	logic [STAT_W-1:0]    overflow_count;
	logic [STAT_W-1:0]    overlap_count;
	logic [STAT_W-1:0]    unexpected_count;

	// Sequencer
	rbec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Capture state and result register
	rbec_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.in_kind          (s_tuser),
		.in_level         (s_tdata[0]),
		.in_time          (s_tdata[32:1]),
		.rotation_start   (rotation_start),
		.rotation_end     (rotation_end),
		.beacon_total     (beacon_total),
		.beacon_index     (beacon_index),
		.fall_time        (fall_time),
		.rise_time        (rise_time),
		.slot_valid       (m_tuser),
		.overflow_count   (overflow_count),
		.overlap_count    (overlap_count),
		.unexpected_count (unexpected_count),
		.last             (m_tlast)
	);

	// Output beat packing
	assign m_tdata = {1'b0, unexpected_count, overlap_count, overflow_count, rise_time,
		fall_time, beacon_index, beacon_total, rotation_end, rotation_start};

endmodule

/* design/rbec_ctrl.sv */
// Controller: accepts events and sequences the result beats of a committed record.
module rbec_ctrl
	import rbec_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					if (stat.commit) begin
						cmd.start = 1'b1;
						state_d   = ST_SEND;
					end
				end
			end
			ST_SEND: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (stat.last) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cmd.next = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* design/rbec_dpath.sv */
// Datapath: acquisition mode, beacon edge table, statistics and the result register.
module rbec_dpath
	import rbec_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  logic                 in_kind,
	input  logic                 in_level,
	input  logic [TIME_BITS-1:0] in_time,
	output logic [TIME_BITS-1:0] rotation_start,
	output logic [TIME_BITS-1:0] rotation_end,
	output logic [CNT_W-1:0]     beacon_total,
	output logic [IDX_W-1:0]     beacon_index,
	output logic [TIME_BITS-1:0] fall_time,
	output logic [TIME_BITS-1:0] rise_time,
	output logic                 slot_valid,
	output logic [STAT_W-1:0]    overflow_count,
	output logic [STAT_W-1:0]    overlap_count,
	output logic [STAT_W-1:0]    unexpected_count,
	output logic                 last
);

	// Record state
	acq_mode_t                mode_q;
	logic [CNT_W-1:0]         count_q;
	logic [TIME_BITS-1:0]     open_q;
	logic [TIME_BITS-1:0]     close_q;
	logic [TIME_BITS-1:0]     fall_q [BEACON_SLOTS];
	logic [TIME_BITS-1:0]     rise_q [BEACON_SLOTS];
	logic [BEACON_SLOTS-1:0]  fall_ok_q;
	logic [STAT_W-1:0]        drop_q;
	logic [STAT_W-1:0]        ext_q;
	logic [STAT_W-1:0]        surp_q;
	logic [TIME_BITS-1:0]     pend_q;
	logic [IDX_W-1:0]         emit_idx_q;

	// Result register
	logic [TIME_BITS-1:0]     o_start_q;
	logic [TIME_BITS-1:0]     o_end_q;
	logic [CNT_W-1:0]         o_total_q;
	logic [IDX_W-1:0]         o_index_q;
	logic [TIME_BITS-1:0]     o_fall_q;
	logic [TIME_BITS-1:0]     o_rise_q;
	logic                     o_valid_q;
	logic [STAT_W-1:0]        o_drop_q;
	logic [STAT_W-1:0]        o_ext_q;
	logic [STAT_W-1:0]        o_surp_q;
	logic                     o_last_q;

	// Event decode
	logic                     beam;
	logic                     is_tick;
	logic                     slot_free;
	logic [IDX_W-1:0]         widx;
	acq_mode_t                mode_lo;
	logic                     laser_on;
	logic                     rise_wr;
	logic                     drop_inc;
	logic                     fall_wr;
	logic                     extend;
	logic [TIME_BITS-1:0]     close_next;

	assign beam       = (in_level == 1'b0);
	assign is_tick    = (in_kind == EVT_TICK);
	assign slot_free  = (count_q < CNT_W'(BEACON_SLOTS));
	assign widx       = count_q[IDX_W-1:0];
	assign mode_lo    = (mode_q == ACQ_LAST) ? ACQ_DISABLED : mode_q;
	assign laser_on   = cmd.take && !is_tick && (mode_q != ACQ_DISABLED);
	assign rise_wr    = laser_on && !beam && (mode_lo != ACQ_IGNORE) && slot_free;
	assign drop_inc   = laser_on && !beam && (mode_lo != ACQ_IGNORE) && !slot_free;
	assign fall_wr    = laser_on && beam && slot_free;
	assign extend     = cmd.take && is_tick && beam && (mode_q == ACQ_STD);
	assign close_next = (mode_q != ACQ_DISABLED) ? in_time : close_q;

	assign stat.commit = is_tick && !(beam && (mode_q == ACQ_STD));
	assign stat.last   = o_last_q;

	// Slot read for the result beat being loaded
	logic [IDX_W-1:0]         rd_idx;
	logic [CNT_W-1:0]         rd_ext;
	logic                     rd_valid;
	logic                     rd_last;
	logic [TIME_BITS-1:0]     rd_fall;
	logic [TIME_BITS-1:0]     rd_rise;

	assign rd_idx   = cmd.start ? '0 : emit_idx_q + IDX_W'(1);
	assign rd_ext   = CNT_W'(rd_idx);
	assign rd_valid = (rd_ext < count_q);
	assign rd_last  = (count_q == '0) || ((rd_ext + CNT_W'(1)) == count_q);
	assign rd_fall  = (rd_valid && fall_ok_q[rd_idx]) ? fall_q[rd_idx] : '0;
	assign rd_rise  = rd_valid ? rise_q[rd_idx] : '0;

	// Mode, counts, statistics, record times and emit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= ACQ_DISABLED;
			count_q    <= '0;
			open_q     <= '0;
			close_q    <= '0;
			fall_ok_q  <= '0;
			drop_q     <= '0;
			ext_q      <= '0;
			surp_q     <= '0;
			emit_idx_q <= '0;
		end else begin
			if (cmd.take) begin
				if (is_tick) begin
					if (mode_q != ACQ_DISABLED) begin
						close_q <= in_time;
					end
					if (extend) begin
						mode_q <= ACQ_LAST;
						ext_q  <= sat_inc(ext_q);
					end else begin
						mode_q <= (mode_q == ACQ_DISABLED) ? ACQ_IGNORE : ACQ_STD;
					end
				end else if (mode_q != ACQ_DISABLED) begin
					if (mode_q == ACQ_LAST && beam) begin
						surp_q <= sat_inc(surp_q);
					end
					if (!beam && mode_lo == ACQ_IGNORE) begin
						mode_q <= ACQ_STD;
					end else begin
						mode_q <= mode_lo;
					end
				end
			end
			if (rise_wr) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (drop_inc) begin
				drop_q <= sat_inc(drop_q);
			end
			if (fall_wr) begin
				fall_ok_q[widx] <= 1'b1;
			end
			if (cmd.start || cmd.next) begin
				emit_idx_q <= rd_idx;
			end
			// record sent: start a fresh rotation at the committing tick
			if (cmd.finish) begin
				count_q   <= '0;
				open_q    <= pend_q;
				close_q   <= '0;
				fall_ok_q <= '0;
				drop_q    <= '0;
				ext_q     <= '0;
				surp_q    <= '0;
			end
		end
	end

	// Edge table, pending tick time and result beat
	always_ff @(posedge clk) begin
		if (fall_wr) begin
			fall_q[widx] <= in_time;
		end
		if (rise_wr) begin
			rise_q[widx] <= in_time;
		end
		if (cmd.start) begin
			pend_q    <= in_time;
			o_start_q <= open_q;
			o_end_q   <= close_next;
			o_total_q <= count_q;
			o_drop_q  <= drop_q;
			o_ext_q   <= ext_q;
			o_surp_q  <= surp_q;
		end
		if (cmd.start || cmd.next) begin
			o_index_q <= rd_idx;
			o_fall_q  <= rd_fall;
			o_rise_q  <= rd_rise;
			o_valid_q <= rd_valid;
			o_last_q  <= rd_last;
		end
	end

	assign rotation_start   = o_start_q;
	assign rotation_end     = o_end_q;
	assign beacon_total     = o_total_q;
	assign beacon_index     = o_index_q;
	assign fall_time        = o_fall_q;
	assign rise_time        = o_rise_q;
	assign slot_valid       = o_valid_q;
	assign overflow_count   = o_drop_q;
	assign overlap_count    = o_ext_q;
	assign unexpected_count = o_surp_q;
	assign last             = o_last_q;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking stream testbench for rotating_beacon_edge_capture with a built-in predictor.
module tb_top;
	import rbec_pkg::*;

	// One result beat of a committed rotation record
	typedef struct packed {
		logic [31:0] rot_start;
		logic [31:0] rot_end;
		logic [3:0]  total;
		logic [2:0]  index;
		logic [31:0] fall;
		logic [31:0] rise;
		logic        valid;
		logic [7:0]  dropped;
		logic [7:0]  extended;
		logic [7:0]  surprise;
		logic        is_last;
	} slot_rec_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [39:0]  s_tdata;   // laser_level[0], timestamp[32:1], zero pad[39:33]
	logic         s_tuser;   // event_kind[0]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [159:0] m_tdata;   // rotation_start .. unexpected_count, zero pad[159]
	logic         m_tuser;   // slot_valid[0]
	logic         m_tlast;

	// Predictor state
	acq_mode_t    acq;
	int unsigned  n_beacons;
	logic [31:0]  t_open;
	logic [31:0]  t_close;
	logic [31:0]  fall_tab [BEACON_SLOTS];
	logic [31:0]  rise_tab [BEACON_SLOTS];
	logic [7:0]   n_dropped;
	logic [7:0]   n_extended;
	logic [7:0]   n_surprise;

	slot_rec_t    pending_slots [$];
	int unsigned  errors;
	int unsigned  events_sent;
	int unsigned  burst_left;
	int unsigned  ready_left;
	int unsigned  stall_left;
	logic [31:0]  now_us;

	rotating_beacon_edge_capture i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [7:0] bump_stat(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	function automatic void clear_rotation();
		n_beacons  = 0;
		t_open     = '0;
		t_close    = '0;
		n_dropped  = '0;
		n_extended = '0;
		n_surprise = '0;
		for (int i = 0; i < BEACON_SLOTS; i++) begin
			fall_tab[i] = '0;
			rise_tab[i] = '0;
		end
	endfunction

	// Queue the result beats of the record held in the predictor
	function automatic void queue_record();
		slot_rec_t   r;
		int unsigned beats;
		beats = (n_beacons == 0) ? 1 : n_beacons;
		for (int unsigned k = 0; k < beats; k++) begin
			r.rot_start = t_open;
			r.rot_end   = t_close;
			r.total     = 4'(n_beacons);
			r.index     = 3'(k);
			r.valid     = (k < n_beacons);
			r.fall      = r.valid ? fall_tab[k] : 32'd0;
			r.rise      = r.valid ? rise_tab[k] : 32'd0;
			r.dropped   = n_dropped;
			r.extended  = n_extended;
			r.surprise  = n_surprise;
			r.is_last   = (k + 1 == beats);
			pending_slots.push_back(r);
		end
	endfunction

	// Advance the capture state by one accepted event
	function automatic void track_beacon_event(input logic kind, input logic level,
		input logic [31:0] stamp);
		logic beam;
		beam = (level == 1'b0);
		if (kind == EVT_TICK) begin
			if (acq != ACQ_DISABLED) t_close = stamp;
			if (beam && acq == ACQ_STD) begin
				// beam straddles the tick: capture one more rotation
				acq        = ACQ_LAST;
				n_extended = bump_stat(n_extended);
			end else begin
				queue_record();
				clear_rotation();
				t_open = stamp;
				acq    = (acq == ACQ_DISABLED) ? ACQ_IGNORE : ACQ_STD;
			end
		end else if (acq != ACQ_DISABLED) begin
			if (acq == ACQ_LAST) begin
				acq = ACQ_DISABLED;
				if (beam) n_surprise = bump_stat(n_surprise);
			end
			if (!beam) begin
				if (acq == ACQ_IGNORE) begin
					acq = ACQ_STD;
				end else if (n_beacons < BEACON_SLOTS) begin
					rise_tab[n_beacons] = stamp;
					n_beacons++;
				end else begin
					n_dropped = bump_stat(n_dropped);
				end
			end else if (n_beacons < BEACON_SLOTS) begin
				fall_tab[n_beacons] = stamp;
			end
		end
	endfunction

	// Send one event beat, idling in bursts on the input side
	task automatic send_event(input logic kind, input logic level, input logic [31:0] stamp);
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {7'b0, stamp, level};
		do @(posedge clk); while (!s_tready);
		track_beacon_event(kind, level, stamp);
		events_sent++;
	endtask

	// Output side stall pattern
	always @(negedge clk) begin
		if (ready_left > 0) begin
			m_tready <= 1'b1;
			ready_left--;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 8);
			stall_left = $urandom_range(1, 6);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare each result beat with the oldest expected slot
	always @(posedge clk) begin
		slot_rec_t want;
		slot_rec_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.rot_start = m_tdata[31:0];
			got.rot_end   = m_tdata[63:32];
			got.total     = m_tdata[67:64];
			got.index     = m_tdata[70:68];
			got.fall      = m_tdata[102:71];
			got.rise      = m_tdata[134:103];
			got.dropped   = m_tdata[142:135];
			got.extended  = m_tdata[150:143];
			got.surprise  = m_tdata[158:151];
			got.valid     = m_tuser;
			got.is_last   = m_tlast;
			if (pending_slots.size() == 0) begin
				$display("%0t ns: result beat mismatch, expected none, actual %0h",
					$time, m_tdata);
				errors++;
			end else begin
				want = pending_slots.pop_front();
				check_field("rotation_start", want.rot_start, got.rot_start);
				check_field("rotation_end", want.rot_end, got.rot_end);
				check_field("beacon_total", 32'(want.total), 32'(got.total));
				check_field("beacon_index", 32'(want.index), 32'(got.index));
				check_field("fall_time", want.fall, got.fall);
				check_field("rise_time", want.rise, got.rise);
				check_field("slot_valid", 32'(want.valid), 32'(got.valid));
				check_field("overflow_count", 32'(want.dropped), 32'(got.dropped));
				check_field("overlap_count", 32'(want.extended), 32'(got.extended));
				check_field("unexpected_count", 32'(want.surprise), 32'(got.surprise));
				check_field("last", 32'(want.is_last), 32'(got.is_last));
				check_field("pad", 32'(1'b0), 32'(m_tdata[159]));
			end
		end
	end

	// Laser activity is ignored until the first tick; that tick sends an all-zero record
	task automatic test_first_tick();
		send_event(EVT_LASER, 1'b0, 32'hFFFF_FFFF);
		send_event(EVT_TICK, 1'b1, 32'h0000_0000);
	endtask

	// First vanish after a tick from disabled is skipped, extreme timestamps kept
	task automatic test_ignore_rise();
		send_event(EVT_LASER, 1'b0, 32'h8000_0000);
		send_event(EVT_LASER, 1'b1, 32'h0000_0001);
		send_event(EVT_LASER, 1'b0, 32'hFFFF_FFFF);
		send_event(EVT_LASER, 1'b1, 32'hFFFF_FFFE);
		send_event(EVT_TICK, 1'b1, 32'h7FFF_FFFF);
	endtask

	// Rotation with no beacons: single beat, slot not valid
	task automatic test_empty_record();
		send_event(EVT_TICK, 1'b1, 32'hA5A5_5A5A);
	endtask

	// Beam across a tick extends capture; then a surprise beam and a late vanish
	task automatic test_overlap();
		send_event(EVT_LASER, 1'b0, 32'd100);
		send_event(EVT_TICK, 1'b0, 32'd200);
		send_event(EVT_LASER, 1'b0, 32'd300);
		send_event(EVT_TICK, 1'b1, 32'd400);
		send_event(EVT_LASER, 1'b1, 32'd500);
		send_event(EVT_LASER, 1'b0, 32'd600);
		send_event(EVT_TICK, 1'b0, 32'd700);
		send_event(EVT_LASER, 1'b1, 32'd800);
		send_event(EVT_TICK, 1'b0, 32'd900);
	endtask

	// Fill every slot, then drop further beacons
	task automatic test_full_table();
		for (int i = 0; i < BEACON_SLOTS + 3; i++)
			send_event(EVT_LASER, 1'b1, 32'h1000 + 32'(i));
		send_event(EVT_LASER, 1'b0, 32'h5555_5555);
		send_event(EVT_TICK, 1'b1, 32'hAAAA_AAAA);
	endtask

	// Enough drops in one rotation to pin the overflow counter
	task automatic test_stat_saturation();
		send_event(EVT_TICK, 1'b1, now_us);
		for (int i = 0; i < BEACON_SLOTS + 258; i++) begin
			now_us += $urandom_range(1, 50);
			send_event(EVT_LASER, 1'b1, now_us);
		end
		send_event(EVT_TICK, 1'b1, now_us + 32'd7);
	endtask

	// Mostly well-formed rotations with random content, some overlaps, some noise
	task automatic test_random_rotations(input int unsigned budget);
		int unsigned stop_at;
		int unsigned nb;
		int unsigned pick;
		stop_at = events_sent + budget;
		while (events_sent < stop_at) begin
			if ($urandom_range(0, 3) == 0) now_us = $urandom();
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				repeat ($urandom_range(3, 8))
					send_event(1'($urandom()), 1'($urandom()), $urandom());
			end else begin
				nb = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12)
					: $urandom_range(0, BEACON_SLOTS);
				for (int unsigned i = 0; i < nb; i++) begin
					now_us += $urandom_range(1, 400);
					send_event(EVT_LASER, 1'b0, now_us);
					now_us += $urandom_range(1, 60);
					send_event(EVT_LASER, 1'b1, now_us);
					if ($urandom_range(0, 15) == 0)
						send_event(1'($urandom()), 1'($urandom()), $urandom());
				end
				if (pick <= 2) begin
					// beam still present at the tick
					now_us += $urandom_range(1, 400);
					send_event(EVT_LASER, 1'b0, now_us);
					now_us += $urandom_range(1, 60);
					send_event(EVT_TICK, 1'b0, now_us);
					now_us += $urandom_range(1, 60);
					case ($urandom_range(0, 2))
						0: send_event(EVT_LASER, 1'b1, now_us);
						1: send_event(EVT_LASER, 1'b0, now_us);
						default: send_event(EVT_TICK, 1'($urandom()), now_us);
					endcase
				end
				now_us += $urandom_range(1, 400);
				send_event(EVT_TICK, 1'b1, now_us);
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = EVT_TICK;
		errors     = 0;
		events_sent = 0;
		burst_left = 0;
		ready_left = 0;
		stall_left = 0;
		now_us     = $urandom();
		acq        = ACQ_DISABLED;
		clear_rotation();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_first_tick();
		test_ignore_rise();
		test_empty_record();
		test_overlap();
		test_full_table();
		test_random_rotations(80);
		test_stat_saturation();
		test_random_rotations(30);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_slots.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
